// ===== hw/rtl/tlfr_pkg.sv =====
// Shared constants for the truss local frame rotation block.
`default_nettype none

package tlfr_pkg;

   localparam int COORD_W       = 32;   // node coordinate, signed Q16.16
   localparam int OUT_W         = 18;   // matrix entry width on the result bus
   localparam int NUM_OUT       = 9;    // matrix entries per result
   localparam int DIM_W         = 2;
   localparam int FRAC_BITS_DEF = 16;

   localparam int REQ_DATA_W    = 6 * COORD_W;                    // 192
   localparam int RSP_DATA_W    = ((NUM_OUT * OUT_W + 7) / 8) * 8; // 168

   // Normalized magnitudes sit in [2^30, 2^31)
   localparam int NORM_W        = 31;
   localparam int NORM_MSB      = 30;
   localparam int SUM_W         = 64;   // sum of three squared magnitudes
   localparam int ROOT_W        = 32;   // integer root, one bit per step

   localparam logic [DIM_W-1:0] DIM_PLANE = 2'd2;
   localparam logic [DIM_W-1:0] DIM_SPACE = 2'd3;

endpackage : tlfr_pkg

`default_nettype wire

// ===== hw/rtl/tlfr_unit.sv =====
// Pipelined vector normalizer: integer root and rounded divide, one step per stage.
`default_nettype none

module tlfr_unit
   import tlfr_pkg::*;
#(
   parameter int VW        = COORD_W + 1,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SW        = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [2:0][VW-1:0]        in_vec,
   input  logic [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic [2:0][FRAC_BITS+1:0] out_vec,
   output logic [SW-1:0]             out_side
);

   localparam int UW = FRAC_BITS + 2;
   localparam int QW = FRAC_BITS + 1;
   localparam int NW = NORM_W + 1 + FRAC_BITS;
   localparam int RW = ROOT_W + 1;
   localparam int PW = $clog2(VW);
   localparam int SQ_W = 2 * NORM_W;

   typedef struct packed {
      logic [SW-1:0] side;
      logic          zero;
      logic [2:0]    neg;
   } ctl_type;

   // stage 1: sign and magnitude
   logic                 v1_ff;
   logic [2:0][VW-1:0]   mag1_in, mag1_ff;
   logic [2:0]           neg1_in, neg1_ff;
   logic [SW-1:0]        side1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][VW-1];
         mag1_in[i] = in_vec[i][VW-1] ? VW'(VW'(0) - in_vec[i]) : in_vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         side1_ff <= in_side;
      end
   end

   // stage 2: leading one of the largest magnitude
   logic               v2_ff;
   logic [VW-1:0]      orv;
   logic [PW-1:0]      p2_in, p2_ff;
   logic [2:0][VW-1:0] mag2_ff;
   ctl_type            ctl2_ff;

   always_comb begin
      orv   = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      p2_in = '0;
      for (int i = 0; i < VW; i++) begin
         if (orv[i]) begin
            p2_in = PW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         p2_ff   <= p2_in;
         mag2_ff <= mag1_ff;
         ctl2_ff <= '{side: side1_ff, zero: (orv == '0), neg: neg1_ff};
      end
   end

   // stage 3: shift every component so the largest lands on bit 30
   logic                   v3_ff;
   logic [2:0][NORM_W-1:0] nm3_in, nm3_ff;
   ctl_type                ctl3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (int'(p2_ff) >= NORM_MSB) begin
            nm3_in[i] = NORM_W'(mag2_ff[i] >> (int'(p2_ff) - NORM_MSB));
         end else begin
            nm3_in[i] = NORM_W'({{NORM_W{1'b0}}, mag2_ff[i]} << (NORM_MSB - int'(p2_ff)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         nm3_ff  <= nm3_in;
         ctl3_ff <= ctl2_ff;
      end
   end

   // stage 4: squares
   logic                   v4_ff;
   logic [2:0][SQ_W-1:0]   sq4_ff;
   logic [2:0][NORM_W-1:0] nm4_ff;
   ctl_type                ctl4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= SQ_W'(nm3_ff[i]) * SQ_W'(nm3_ff[i]);
         end
         nm4_ff  <= nm3_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   // stage 5: sum of squares
   logic                   v5_ff;
   logic [SUM_W-1:0]       sum5_ff;
   logic [2:0][NORM_W-1:0] nm5_ff;
   ctl_type                ctl5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         sum5_ff <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
         nm5_ff  <= nm4_ff;
         ctl5_ff <= ctl4_ff;
      end
   end

   // integer square root, one result bit per stage
   logic                   sv_ff  [0:ROOT_W-1];
   logic [SUM_W-1:0]       sx_ff  [0:ROOT_W-1];
   logic [SUM_W-1:0]       sr_ff  [0:ROOT_W-1];
   logic [2:0][NORM_W-1:0] snm_ff [0:ROOT_W-1];
   ctl_type                sctl_ff[0:ROOT_W-1];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
      logic                   vi;
      logic [SUM_W-1:0]       xi, ri, t;
      logic [2:0][NORM_W-1:0] nmi;
      ctl_type                ci;

      if (k == 0) begin : g_first
         assign vi  = v5_ff;
         assign xi  = sum5_ff;
         assign ri  = '0;
         assign nmi = nm5_ff;
         assign ci  = ctl5_ff;
      end else begin : g_next
         assign vi  = sv_ff[k-1];
         assign xi  = sx_ff[k-1];
         assign ri  = sr_ff[k-1];
         assign nmi = snm_ff[k-1];
         assign ci  = sctl_ff[k-1];
      end

      assign t = ri + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (en) begin
            sv_ff[k] <= vi;
         end
         if (en) begin
            if (xi >= t) begin
               sx_ff[k] <= xi - t;
               sr_ff[k] <= (ri >> 1) + BIT;
            end else begin
               sx_ff[k] <= xi;
               sr_ff[k] <= ri >> 1;
            end
            snm_ff[k]  <= nmi;
            sctl_ff[k] <= ci;
         end
      end
   end

   // divide setup: numerator with half the divisor for rounding
   logic                  d0v_ff;
   logic [ROOT_W-1:0]     root, d0r_ff;
   logic [2:0][NW-1:0]    num;
   logic [2:0][RW-1:0]    d0rem_ff;
   logic [2:0][QW-1:0]    d0low_ff;
   ctl_type               d0ctl_ff;

   assign root = sr_ff[ROOT_W-1][ROOT_W-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = NW'({snm_ff[ROOT_W-1][i], {FRAC_BITS{1'b0}}}) + NW'(root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0v_ff <= 1'b0;
      end else if (en) begin
         d0v_ff <= sv_ff[ROOT_W-1];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d0rem_ff[i] <= RW'(num[i][NW-1:QW]);
            d0low_ff[i] <= num[i][QW-1:0];
         end
         d0r_ff   <= root;
         d0ctl_ff <= sctl_ff[ROOT_W-1];
      end
   end

   // restoring divide, one quotient bit per stage
   logic               dv_ff  [0:QW-1];
   logic [2:0][RW-1:0] drem_ff[0:QW-1];
   logic [2:0][QW-1:0] dlow_ff[0:QW-1];
   logic [2:0][QW-1:0] dq_ff  [0:QW-1];
   logic [ROOT_W-1:0]  dr_ff  [0:QW-1];
   ctl_type            dctl_ff[0:QW-1];

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic               vi;
      logic [2:0][RW-1:0] remi;
      logic [2:0][QW-1:0] lowi, qi;
      logic [ROOT_W-1:0]  ri;
      ctl_type            ci;

      if (j == 0) begin : g_first
         assign vi   = d0v_ff;
         assign remi = d0rem_ff;
         assign lowi = d0low_ff;
         assign qi   = '0;
         assign ri   = d0r_ff;
         assign ci   = d0ctl_ff;
      end else begin : g_next
         assign vi   = dv_ff[j-1];
         assign remi = drem_ff[j-1];
         assign lowi = dlow_ff[j-1];
         assign qi   = dq_ff[j-1];
         assign ri   = dr_ff[j-1];
         assign ci   = dctl_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= vi;
         end
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if ({remi[i][RW-2:0], lowi[i][QW-1-j]} >= RW'(ri)) begin
                  drem_ff[j][i] <= {remi[i][RW-2:0], lowi[i][QW-1-j]} - RW'(ri);
                  dq_ff[j][i]   <= {qi[i][QW-2:0], 1'b1};
               end else begin
                  drem_ff[j][i] <= {remi[i][RW-2:0], lowi[i][QW-1-j]};
                  dq_ff[j][i]   <= {qi[i][QW-2:0], 1'b0};
               end
            end
            dlow_ff[j] <= lowi;
            dr_ff[j]   <= ri;
            dctl_ff[j] <= ci;
         end
      end
   end

   // sign and zero vector
   logic                 ov_ff;
   logic [2:0][UW-1:0]   o_ff;
   logic [SW-1:0]        oside_ff;
   ctl_type              cl;

   assign cl = dctl_ff[QW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[QW-1];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (cl.zero) begin
               o_ff[i] <= '0;
            end else if (cl.neg[i]) begin
               o_ff[i] <= UW'(0) - UW'(dq_ff[QW-1][i]);
            end else begin
               o_ff[i] <= UW'(dq_ff[QW-1][i]);
            end
         end
         oside_ff <= cl.side;
      end
   end

   assign out_valid = ov_ff;
   assign out_vec   = o_ff;
   assign out_side  = oside_ff;

endmodule : tlfr_unit

`default_nettype wire

// ===== hw/rtl/truss_local_frame_rotation.sv =====
// Top level: truss element local frame, streaming in and out.
// Throughput: one item per cycle unless the output stalls.
// Each normalizer runs a 32-stage root and a FRAC_BITS+1 stage divide, and two
// normalizers sit in series around the cross product.
// Backpressure stalls the whole pipeline at once; the last stage is the output register.
// Reset (synchronous, active high) clears all valid bits and sets space_dimension to 3.
`default_nettype none

module truss_local_frame_rotation
   import tlfr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // axis_x/y/z, normal_x/y/z, binormal_x/y/z (18 bits each), 6 zero pad bits
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DIM_W-1:0]      csr_data
);

   localparam int DW   = COORD_W + 1;   // coordinate difference
   localparam int UW   = FRAC_BITS + 2; // unit vector component
   localparam int PRW  = 2 * UW;        // cross product term
   localparam int CW   = PRW + 1;       // cross product component
   localparam int SWB  = 6 * UW + 2;

   // space_dimension register; codes other than plane act as space
   logic [DIM_W-1:0] dim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_SPACE;
      end else if (csr_valid) begin
         dim_ff <= csr_data;
      end
   end

   // one enable for every stage: advance unless the result is held
   logic en;
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // input stage: axis, its partner vector and the zero-length flag
   logic               plane;
   logic [2:0][DW-1:0] d_in, nv_in;
   logic               degen_in;

   always_comb begin
      plane   = (dim_ff == DIM_PLANE);
      d_in[0] = DW'($signed(req_tdata[4*COORD_W-1:3*COORD_W]))
              - DW'($signed(req_tdata[COORD_W-1:0]));
      d_in[1] = DW'($signed(req_tdata[5*COORD_W-1:4*COORD_W]))
              - DW'($signed(req_tdata[2*COORD_W-1:COORD_W]));
      d_in[2] = plane ? '0 : DW'($signed(req_tdata[6*COORD_W-1:5*COORD_W]))
                           - DW'($signed(req_tdata[3*COORD_W-1:2*COORD_W]));
      degen_in = (d_in[0] == '0) && (d_in[1] == '0) && (d_in[2] == '0);
      // cross with unit Z, or with unit X for an axis along Z
      if (d_in[0] != '0 || d_in[1] != '0) begin
         nv_in[0] = d_in[1];
         nv_in[1] = DW'(0) - d_in[0];
         nv_in[2] = '0;
      end else begin
         nv_in[0] = '0;
         nv_in[1] = d_in[2];
         nv_in[2] = DW'(0) - d_in[1];
      end
   end

   logic               v0_ff;
   logic [2:0][DW-1:0] d0_ff, nv0_ff;
   logic [1:0]         side0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
      if (en) begin
         d0_ff    <= d_in;
         nv0_ff   <= nv_in;
         side0_ff <= {plane, degen_in};
      end
   end

   // normalize axis and partner side by side
   logic               av;
   logic [2:0][UW-1:0] a_vec, n_vec;
   logic [1:0]         a_side;

   tlfr_unit #(.VW(DW), .FRAC_BITS(FRAC_BITS), .SW(2)) u_axis (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (d0_ff),
      .in_side   (side0_ff),
      .out_valid (av),
      .out_vec   (a_vec),
      .out_side  (a_side)
   );

   tlfr_unit #(.VW(DW), .FRAC_BITS(FRAC_BITS), .SW(1)) u_normal (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (nv0_ff),
      .in_side   (1'b0),
      .out_valid (),
      .out_vec   (n_vec),
      .out_side  ()
   );

   // cross product, stage one: six products
   logic                x1v_ff;
   logic [5:0][PRW-1:0] prod_ff;
   logic [2:0][UW-1:0]  a1_ff, n1_ff;
   logic [1:0]          side1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1v_ff <= 1'b0;
      end else if (en) begin
         x1v_ff <= av;
      end
      if (en) begin
         prod_ff[0] <= PRW'($signed(a_vec[1])) * PRW'($signed(n_vec[2]));
         prod_ff[1] <= PRW'($signed(a_vec[2])) * PRW'($signed(n_vec[1]));
         prod_ff[2] <= PRW'($signed(a_vec[2])) * PRW'($signed(n_vec[0]));
         prod_ff[3] <= PRW'($signed(a_vec[0])) * PRW'($signed(n_vec[2]));
         prod_ff[4] <= PRW'($signed(a_vec[0])) * PRW'($signed(n_vec[1]));
         prod_ff[5] <= PRW'($signed(a_vec[1])) * PRW'($signed(n_vec[0]));
         a1_ff      <= a_vec;
         n1_ff      <= n_vec;
         side1_ff   <= a_side;
      end
   end

   // cross product, stage two: differences
   logic               x2v_ff;
   logic [2:0][CW-1:0] c2_ff;
   logic [SWB-1:0]     side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x2v_ff <= 1'b0;
      end else if (en) begin
         x2v_ff <= x1v_ff;
      end
      if (en) begin
         c2_ff[0] <= CW'($signed(prod_ff[0])) - CW'($signed(prod_ff[1]));
         c2_ff[1] <= CW'($signed(prod_ff[2])) - CW'($signed(prod_ff[3]));
         c2_ff[2] <= CW'($signed(prod_ff[4])) - CW'($signed(prod_ff[5]));
         side2_ff <= {a1_ff, n1_ff, side1_ff};
      end
   end

   // normalize the third basis vector; axis and normal ride along
   logic               bv;
   logic [2:0][UW-1:0] b_vec, a3, n3;
   logic [SWB-1:0]     b_side;
   logic               plane3, degen3;

   tlfr_unit #(.VW(CW), .FRAC_BITS(FRAC_BITS), .SW(SWB)) u_binormal (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x2v_ff),
      .in_vec    (c2_ff),
      .in_side   (side2_ff),
      .out_valid (bv),
      .out_vec   (b_vec),
      .out_side  (b_side)
   );

   assign {a3, n3, plane3, degen3} = b_side;

   // output register: drop the unused rows in plane mode, zero all when degenerate
   logic [NUM_OUT-1:0][OUT_W-1:0] ent_in;
   logic [RSP_DATA_W-1:0]         rsp_data_ff;
   logic                          rsp_user_ff;

   always_comb begin
      ent_in[0] = OUT_W'($signed(a3[0]));
      ent_in[1] = OUT_W'($signed(a3[1]));
      ent_in[2] = plane3 ? '0 : OUT_W'($signed(a3[2]));
      ent_in[3] = OUT_W'($signed(n3[0]));
      ent_in[4] = OUT_W'($signed(n3[1]));
      ent_in[5] = plane3 ? '0 : OUT_W'($signed(n3[2]));
      ent_in[6] = plane3 ? '0 : OUT_W'($signed(b_vec[0]));
      ent_in[7] = plane3 ? '0 : OUT_W'($signed(b_vec[1]));
      ent_in[8] = plane3 ? '0 : OUT_W'($signed(b_vec[2]));
      if (degen3) begin
         ent_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= bv;
      end
      if (en) begin
         rsp_data_ff <= RSP_DATA_W'(ent_in);
         rsp_user_ff <= degen3;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule : truss_local_frame_rotation

`default_nettype wire

// ===== hw/rtl/tlfr_checker.sv =====
// Port checker for the truss local frame block, bound to the top level.
`default_nettype none

module tlfr_checker
   import tlfr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]            rsp_tuser,
   input wire logic                  csr_ready
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // a degenerate element carries an all-zero matrix
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate item with nonzero matrix");

   // the pipeline stalls as one: input held exactly while output is held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   // no result appears right after a reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // the register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr write port not ready");

endmodule : tlfr_checker

bind truss_local_frame_rotation tlfr_checker u_tlfr_checker (.*);

`default_nettype wire

// ===== sim/truss_local_frame_rotation_tb.sv =====
// Testbench for the truss local frame rotation block: directed table plus random items.
`default_nettype none

module truss_local_frame_rotation_tb;
   import tlfr_pkg::*;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int LATENCY   = 2 * FRAC + 84;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 450;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [OUT_W-1:0] entry_type;

   typedef struct packed {
      coord_type end_z, end_y, end_x, start_z, start_y, start_x;
   } nodes_type;

   typedef struct {
      entry_type m[NUM_OUT];
      logic      degenerate;
   } frame_type;

   typedef struct {
      nodes_type nodes;
      logic      has_frame;  // frame below was typed in by hand
      frame_type frame;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [DIM_W-1:0] csr_data = '0;

   // Frames still owed by the block, oldest first.
   frame_type pending_frames[$];
   logic [DIM_W-1:0] dim_shadow;
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #4 clock = ~clock;

   truss_local_frame_rotation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Bitwise integer root of a 64-bit value.
   function automatic logic [63:0] int_root(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scale a vector to unit length in Q.FRAC, rounding half away from zero.
   function automatic void unit_vector(input longint v[3], output longint u[3]);
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] peak, sumsq, root, q;
      peak = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > peak) peak = mag[i];
      end
      if (peak == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return;
      end
      while (peak >= (64'd1 << 31)) begin
         peak >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (peak < (64'd1 << 30)) begin
         peak <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      root = int_root(sumsq);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FRAC) + (root >> 1)) / root;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   // Expected rotation matrix for one element under the current dimension.
   function automatic frame_type element_frame(nodes_type n, logic [DIM_W-1:0] dim);
      frame_type f;
      logic plane;
      longint d[3], nv[3], a[3], nn[3], c[3], b[3], res[NUM_OUT];
      plane = (dim == DIM_PLANE);
      d[0] = longint'(n.end_x) - longint'(n.start_x);
      d[1] = longint'(n.end_y) - longint'(n.start_y);
      d[2] = plane ? 0 : longint'(n.end_z) - longint'(n.start_z);
      for (int i = 0; i < NUM_OUT; i++) res[i] = 0;
      f.degenerate = (d[0] == 0 && d[1] == 0 && d[2] == 0);
      if (!f.degenerate) begin
         if (d[0] != 0 || d[1] != 0) begin
            nv[0] = d[1]; nv[1] = -d[0]; nv[2] = 0;
         end else begin
            nv[0] = 0; nv[1] = d[2]; nv[2] = -d[1];
         end
         unit_vector(d, a);
         unit_vector(nv, nn);
         c[0] = a[1] * nn[2] - a[2] * nn[1];
         c[1] = a[2] * nn[0] - a[0] * nn[2];
         c[2] = a[0] * nn[1] - a[1] * nn[0];
         unit_vector(c, b);
         res[0] = a[0]; res[1] = a[1]; res[3] = nn[0]; res[4] = nn[1];
         if (!plane) begin
            res[2] = a[2]; res[5] = nn[2];
            res[6] = b[0]; res[7] = b[1]; res[8] = b[2];
         end
      end
      for (int i = 0; i < NUM_OUT; i++) f.m[i] = entry_type'(res[i]);
      return f;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // Random receiver stall, sampled result checked at each accepting edge.
   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[OUT_W-1:0], 0);
            end else begin
               want = pending_frames.pop_front();
               for (int i = 0; i < NUM_OUT; i++)
                  if (rsp_tdata[i*OUT_W +: OUT_W] !== want.m[i])
                     report_mismatch($sformatf("entry %0d", i),
                                     rsp_tdata[i*OUT_W +: OUT_W], want.m[i]);
               if (rsp_tuser[0] !== want.degenerate)
                  report_mismatch("degenerate", rsp_tuser[0], want.degenerate);
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired at %0t", $time);
         $display("truss_local_frame_rotation test failed");
         $finish;
      end
   end

   // Present one item, holding it until accepted; predict at acceptance.
   // Valid stays high afterwards so the next item can follow without a gap.
   task automatic send_item(nodes_type n, bit typed, frame_type typed_frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= n;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_frames.push_back(typed ? typed_frame : element_frame(n, dim_shadow));
   endtask

   // Drop valid, drain, and let the pipeline settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_dimension(logic [DIM_W-1:0] dim);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= dim;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      dim_shadow = dim;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(5))
         0: return coord_type'($urandom_range(7) - 3);
         1: return coord_type'(32'h8000_0000 + $urandom_range(3));
         2: return coord_type'(32'h7FFF_FFFF - $urandom_range(3));
         3: return coord_type'($urandom_range(32'hFFFF) << 16);
         default: return coord_type'($urandom());
      endcase
   endfunction

   // Random element; bias toward shared nodes and axis-aligned members.
   function automatic nodes_type rand_element();
      nodes_type n;
      n = {rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord()};
      case ($urandom_range(9))
         0: begin n.end_x = n.start_x; n.end_y = n.start_y; end
         1: begin n.end_x = n.start_x; n.end_y = n.start_y; n.end_z = n.start_z; end
         2: n.end_x = n.start_x;
         3: n.end_y = n.start_y;
         4: n.end_z = n.start_z;
         default: ;
      endcase
      return n;
   endfunction

   function automatic row_type checked(coord_type sx, coord_type sy, coord_type sz,
                                       coord_type ex, coord_type ey, coord_type ez);
      row_type r;
      r.nodes = {ez, ey, ex, sz, sy, sx};
      r.has_frame = 1'b0;
      r.frame = '{default: '0};
      return r;
   endfunction

   function automatic row_type typed_row(coord_type sx, coord_type sy, coord_type sz,
                                         coord_type ex, coord_type ey, coord_type ez,
                                         entry_type m[NUM_OUT], logic degen);
      row_type r;
      r = checked(sx, sy, sz, ex, ey, ez);
      r.has_frame = 1'b1;
      r.frame.m = m;
      r.frame.degenerate = degen;
      return r;
   endfunction

   localparam entry_type ONE  = entry_type'(1 << FRAC);
   localparam entry_type MONE = entry_type'(-(1 << FRAC));

   initial begin
      row_type directed[$];
      entry_type zero9[NUM_OUT];
      logic [DIM_W-1:0] dims[6];
      int rounds;

      zero9 = '{default: '0};
      // Zero length, unit x axis, z-only axis (second vector about x), extremes.
      directed.push_back(typed_row(0, 0, 0, 0, 0, 0, zero9, 1'b1));
      directed.push_back(typed_row(32'sh7FFF_FFFF, 5, -7, 32'sh7FFF_FFFF, 5, -7,
                                   zero9, 1'b1));
      directed.push_back(typed_row(0, 0, 0, 32'sh0001_0000, 0, 0,
                                   '{ONE, 0, 0, 0, MONE, 0, 0, 0, MONE}, 1'b0));
      directed.push_back(typed_row(0, 0, 0, 0, 0, 32'sh0001_0000,
                                   '{0, 0, ONE, 0, ONE, 0, MONE, 0, 0}, 1'b0));
      directed.push_back(checked(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      directed.push_back(checked(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
      directed.push_back(checked(0, 0, 0, 1, 0, 0));
      directed.push_back(checked(0, 0, 0, 0, -1, 0));
      directed.push_back(checked(0, 0, 0, 1, 1, 1));
      directed.push_back(checked(0, 0, 0, 0, 1, 0));
      directed.push_back(checked(3, 3, 0, 3, 3, -1));
      directed.push_back(checked(-1, -1, -1, -1, -1, -1));
      directed.push_back(checked(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678,
                                 32'shAAAA_AAAA, 32'sh5555_5555, 32'shEDCB_A987));
      directed.push_back(checked(0, 0, 0, 32'sh0003_0000, 32'sh0004_0000, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      dim_shadow = DIM_SPACE;

      // Directed table at reset dimension.
      foreach (directed[i])
         send_item(directed[i].nodes, directed[i].has_frame, directed[i].frame);
      // Plane mode: the same rows, all predicted.
      write_dimension(DIM_PLANE);
      foreach (directed[i]) send_item(directed[i].nodes, 1'b0, directed[i].frame);

      // Random part over several dimension settings and idling profiles.
      dims = '{DIM_SPACE, DIM_PLANE, 2'd0, 2'd1, DIM_PLANE, DIM_SPACE};
      for (int ph = 0; ph < 6; ph++) begin
         write_dimension(dims[ph]);
         case (ph / 2)
            0: begin send_idle_pct = 19; recv_idle_pct = 81; end
            1: begin send_idle_pct = 81; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         rounds = N_RANDOM / 6;
         for (int k = 0; k < rounds; k++) begin
            // Hold off once mid-phase until the pipeline runs dry.
            if (k == rounds / 2 && ph == 1) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_frames.size() != 0) @(posedge clock);
            end
            send_item(rand_element(), 1'b0, directed[0].frame);
         end
      end

      wait_drained();
      if (errors == 0)
         $display("truss_local_frame_rotation test passed");
      else
         $display("truss_local_frame_rotation test failed");
      $finish;
   end

endmodule

`default_nettype wire
